/* src/mst_pkg.sv */
package mst_pkg;

  localparam int unsigned IdW    = 63;
  localparam int unsigned CountW = 7;
  localparam int unsigned StepW  = 3;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]     op;
    logic [IdW-1:0] member_id;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] member_count;
  } out_t;

  // jump conditions of the sequencer
  typedef enum logic [1:0] {
    JC_ALWAYS   = 2'd0,
    JC_IN_WAIT  = 2'd1,
    JC_IDX_MORE = 2'd2,
    JC_OUT_BUSY = 2'd3
  } jc_e;

  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_CLR    = step_t'(0);
  localparam step_t STEP_IDLE   = step_t'(1);
  localparam step_t STEP_SCAN   = step_t'(2);
  localparam step_t STEP_DRAIN  = step_t'(3);
  localparam step_t STEP_COMMIT = step_t'(4);

  typedef struct packed {
    logic in_rdy;
    logic idx_clr;
    logic idx_inc;
    logic mem_rd;
    logic mem_clr;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    jc_e   cond;
    step_t nxt_t;
    step_t nxt_f;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic idx_more;
    logic out_busy;
  } stat_t;

  // control store
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    w = '0;
    case (step)
      STEP_CLR: begin
        w.ctrl.idx_inc = 1'b1;
        w.ctrl.mem_clr = 1'b1;
        w.cond         = JC_IDX_MORE;
        w.nxt_t        = STEP_CLR;
        w.nxt_f        = STEP_IDLE;
      end
      STEP_IDLE: begin
        w.ctrl.in_rdy  = 1'b1;
        w.ctrl.idx_clr = 1'b1;
        w.cond         = JC_IN_WAIT;
        w.nxt_t        = STEP_IDLE;
        w.nxt_f        = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.ctrl.idx_inc = 1'b1;
        w.ctrl.mem_rd  = 1'b1;
        w.cond         = JC_IDX_MORE;
        w.nxt_t        = STEP_SCAN;
        w.nxt_f        = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        w.cond  = JC_ALWAYS;
        w.nxt_t = STEP_COMMIT;
        w.nxt_f = STEP_COMMIT;
      end
      STEP_COMMIT: begin
        w.ctrl.commit = 1'b1;
        w.cond        = JC_OUT_BUSY;
        w.nxt_t       = STEP_COMMIT;
        w.nxt_f       = STEP_IDLE;
      end
      default: begin
        w.cond  = JC_ALWAYS;
        w.nxt_t = STEP_IDLE;
        w.nxt_f = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/mst_seq.sv */
module mst_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mst_pkg::stat_t stat_i,
  output mst_pkg::ctrl_t ctrl_o
);

  mst_pkg::step_t  pc_q, pc_d;
  mst_pkg::uword_t uw;
  logic            taken;

  always_comb begin
    uw = mst_pkg::ucode_rom(pc_q);
    case (uw.cond)
      mst_pkg::JC_ALWAYS:   taken = 1'b1;
      mst_pkg::JC_IN_WAIT:  taken = !stat_i.in_valid;
      mst_pkg::JC_IDX_MORE: taken = stat_i.idx_more;
      mst_pkg::JC_OUT_BUSY: taken = stat_i.out_busy;
      default:              taken = 1'b1;
    endcase
    pc_d   = taken ? uw.nxt_t : uw.nxt_f;
    ctrl_o = uw.ctrl;
  end

  // reset lands on the clearing loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mst_pkg::STEP_CLR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* src/mst_dp.sv */
module mst_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mst_pkg::ctrl_t ctrl_i,
  input  logic           in_accept_i,
  input  mst_pkg::in_t   in_data_i,
  input  logic           out_busy_i,
  output logic           idx_more_o,
  output logic           res_load_o,
  output mst_pkg::out_t  res_o
);

  localparam int unsigned IdW  = mst_pkg::IdW;
  localparam int unsigned EntW = IdW + 1;
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW = CntW + mst_pkg::CountW;

  // entry: valid mark on top of the identifier
  logic [EntW-1:0] mem [CAPACITY];
  logic [EntW-1:0] rdata_q;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_q;
  logic [1:0]      op_q;
  logic [IdW-1:0]  id_q;
  logic            hit_q, hit_d, free_q, free_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [CntW-1:0] count_q, count_d;

  logic            rd_hit, rd_free, do_commit, ok;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [EntW-1:0] wdata;
  logic [ExtW-1:0] count_ext;

  assign idx_more_o = (idx_q != IdxW'(CAPACITY - 1));

  assign rd_hit  = rd_q && rdata_q[IdW] && (rdata_q[IdW-1:0] == id_q);
  assign rd_free = rd_q && !rdata_q[IdW];

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  // scan results, compared in the cycle after each slot is read
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (in_accept_i) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else begin
      if (rd_hit) begin
        hit_d     = 1'b1;
        hit_idx_d = rd_idx_q;
      end
      if (rd_free && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  assign do_commit = ctrl_i.commit && !out_busy_i;

  always_comb begin
    we      = ctrl_i.mem_clr;
    waddr   = idx_q;
    wdata   = '0;
    count_d = count_q;
    ok      = 1'b0;
    if (do_commit) begin
      case (op_q)
        mst_pkg::OP_ADD: begin
          if (hit_q) begin
            ok = 1'b1;
          end else if (free_q) begin
            we      = 1'b1;
            waddr   = free_idx_q;
            wdata   = {1'b1, id_q};
            count_d = count_q + CntW'(1);
            ok      = 1'b1;
          end
        end
        mst_pkg::OP_DEL: begin
          if (hit_q) begin
            we    = 1'b1;
            waddr = hit_idx_q;
            if (count_q != '0) begin
              count_d = count_q - CntW'(1);
            end
            ok = 1'b1;
          end
        end
        mst_pkg::OP_CHECK: begin
          ok = hit_q;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
    count_ext = ExtW'(count_d);
    res_o.ok           = ok;
    res_o.member_count = count_ext[mst_pkg::CountW-1:0];
  end

  assign res_load_o = do_commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      rd_q    <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      rd_q    <= ctrl_i.mem_rd;
      hit_q   <= hit_d;
      free_q  <= free_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      op_q <= in_data_i.op;
      id_q <= in_data_i.member_id;
    end
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    rd_idx_q   <= idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.mem_rd) begin
      rdata_q <= mem[idx_q];
    end
  end

endmodule

/* src/membership_set_table_unit.sv */
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+---------------------
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (out_t)
//
// after the input transfer the result comes from a scan in which one slot of the
// identifier memory is read and compared per cycle on its single read port, then a drain
// and a commit step; in_ready_o rises with out_valid_o, so items do not overlap
// after reset a clearing pass marks every slot empty;
// in_ready_o stays low until it ends
// a result waits in the output register; a stalled output holds the commit step
module membership_set_table_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mst_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mst_pkg::out_t out_data_o
);

  mst_pkg::ctrl_t ctrl;
  mst_pkg::stat_t stat;
  mst_pkg::out_t  res;
  mst_pkg::out_t  out_q;
  logic           out_valid_q;
  logic           res_load;
  logic           idx_more;
  logic           out_busy;

  assign out_busy   = out_valid_q && !out_ready_i;
  assign in_ready_o = ctrl.in_rdy;

  always_comb begin
    stat.in_valid = in_valid_i;
    stat.idx_more = idx_more;
    stat.out_busy = out_busy;
  end

  mst_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_accept_i (in_valid_i && ctrl.in_rdy),
    .in_data_i   (in_data_i),
    .out_busy_i  (out_busy),
    .idx_more_o  (idx_more),
    .res_load_o  (res_load),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
